>>> hw/rtl/swrf_pkg.sv
// Shared constants for the sliding window rank filter.
// No dependencies; imported by sliding_window_rank_filter_sum.
package swrf_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Port widths fixed by the interface.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_W       = 7;
  localparam int DATA_W      = 32;
  localparam int TOTAL_W     = 64;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LEN    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANK_FROM_TOP = 8'd1;

  // Register reset values.
  localparam logic [REG_W-1:0] WINDOW_LEN_RST    = 7'd64;
  localparam logic [REG_W-1:0] RANK_FROM_TOP_RST = 7'd1;

endpackage

>>> hw/rtl/sliding_window_rank_filter_sum.sv
// Sliding window rank order filter with a wrapping running sum.
// Depends on swrf_pkg for default sizes, port widths and register codes.

// The block accepts one sample per clock while the output is not stalled
// and returns one result beat per sample, registered through stage 1,
// stage 2 and the output stage. The rate of one sample per cycle is set
// by the value-sorted copy of the newest MAX_WINDOW samples: each slot
// carries its age, and on every beat the oldest slot is dropped and the
// new sample is inserted in one step through a row of parallel compares.
// A second stage marks the slots that are inside the current window, counts
// them with a log-depth prefix adder and picks the slot of the requested
// rank; the last stage adds the value to the total. A beat flagged as last
// clears the fill count and the total, so no clearing pass is needed. A stall
// on the output holds the whole pipeline, and in_ready follows out_ready.
module sliding_window_rank_filter_sum
  import swrf_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input samples.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [DATA_W-1:0]  in_sample,
  input  logic                      in_last_sample,
  // Results.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_window_full,
  output logic signed [DATA_W-1:0]  out_selected_value,
  output logic signed [TOTAL_W-1:0] out_running_total,
  // Configuration writes.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int N  = MAX_WINDOW;
  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = $clog2(N + 1);
  localparam int AW = (N > 1) ? $clog2(N) : 1;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic [AW-1:0]        age_t;
  typedef logic [CW-1:0]        count_t;

  // Configuration registers.
  logic [REG_W-1:0] window_len_r;
  logic [REG_W-1:0] rank_r;

  // Sorted window state and stage 1 control.
  sample_t val_r [N];
  age_t    age_r [N];
  count_t  fill_r;
  logic    v1_r, full1_r, last1_r;

  // Stage 2 and output stage.
  sample_t sel2_r;
  logic    v2_r, full2_r, last2_r;
  logic signed [TOTAL_W-1:0] sum_r;
  logic    out_valid_r, out_full_r;
  logic signed [DATA_W-1:0]  out_sel_r;
  logic signed [TOTAL_W-1:0] out_total_r;

  logic adv;
  logic accept;

  // The whole pipeline moves unless a result waits on a stalled output.
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign accept    = in_valid && adv;
  assign cfg_ready = 1'b1;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WINDOW_LEN_RST;
      rank_r       <= RANK_FROM_TOP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW_LEN:    window_len_r <= cfg_data[REG_W-1:0];
        CFG_RANK_FROM_TOP: rank_r       <= cfg_data[REG_W-1:0];
        default:           ;
      endcase
    end
  end

  // Effective window length, rank and the ascending position to select.
  count_t len_eff, rank_eff, kp1;
  always_comb begin
    if (window_len_r == '0) begin
      len_eff = count_t'(1);
    end else if (32'(window_len_r) > N) begin
      len_eff = count_t'(N);
    end else begin
      len_eff = count_t'(window_len_r);
    end
    if (rank_r == '0) begin
      rank_eff = count_t'(1);
    end else if (32'(rank_r) > 32'(len_eff)) begin
      rank_eff = len_eff;
    end else begin
      rank_eff = count_t'(rank_r);
    end
    kp1 = count_t'(len_eff - rank_eff + count_t'(1));
  end

  // Stage 1: drop the oldest slot and insert the new sample in order.
  sample_t s_in;
  logic [N-1:0] hot;
  age_t    d_idx;
  sample_t rem_val [N];
  age_t    rem_age [N];
  logic [N-1:0] less;
  sample_t val_nxt [N];
  age_t    age_nxt [N];
  count_t  fill_inc;

  assign s_in = in_sample[SW-1:0];

  always_comb begin
    int q;
    int pm;
    for (int p = 0; p < N; p++) begin
      hot[p] = (age_r[p] == age_t'(N - 1));
    end
    d_idx = '0;
    for (int p = 0; p < N; p++) begin
      if (hot[p]) begin
        d_idx = d_idx | age_t'(p);
      end
    end
    // Close the gap left by the oldest slot.
    for (int p = 0; p < N; p++) begin
      q = (p < N - 1) ? p + 1 : p;
      if (p < N - 1 && age_t'(p) >= d_idx) begin
        rem_val[p] = val_r[q];
        rem_age[p] = age_r[q];
      end else begin
        rem_val[p] = val_r[p];
        rem_age[p] = age_r[p];
      end
      less[p] = (p < N - 1) && (rem_val[p] < s_in);
    end
    // Shift the upper part by one and place the sample at the boundary.
    for (int p = 0; p < N; p++) begin
      pm = (p > 0) ? p - 1 : 0;
      if (less[p]) begin
        val_nxt[p] = rem_val[p];
        age_nxt[p] = age_t'(rem_age[p] + age_t'(1));
      end else if (p == 0 || less[pm]) begin
        val_nxt[p] = s_in;
        age_nxt[p] = '0;
      end else begin
        val_nxt[p] = rem_val[pm];
        age_nxt[p] = age_t'(rem_age[pm] + age_t'(1));
      end
    end
    fill_inc = (fill_r == count_t'(N)) ? fill_r : count_t'(fill_r + count_t'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < N; p++) begin
        val_r[p] <= '0;
        age_r[p] <= age_t'(p);
      end
      fill_r <= '0;
      v1_r   <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      if (in_valid) begin
        for (int p = 0; p < N; p++) begin
          val_r[p] <= val_nxt[p];
          age_r[p] <= age_nxt[p];
        end
        fill_r <= in_last_sample ? '0 : fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      full1_r <= (fill_inc >= len_eff);
      last1_r <= in_last_sample;
    end
  end

  // Stage 2: count in-window slots in sorted order and pick the wanted one.
  logic [N-1:0] in_win;
  count_t  cnt [N];
  count_t  cnt_prev [N];
  logic [N-1:0] hit;
  sample_t sel_val;

  always_comb begin
    int q;
    for (int p = 0; p < N; p++) begin
      in_win[p] = (count_t'(age_r[p]) < len_eff);
      cnt[p]    = count_t'(in_win[p]);
    end
    cnt_prev = cnt;
    for (int d = 1; d < N; d = d * 2) begin
      cnt_prev = cnt;
      for (int p = 0; p < N; p++) begin
        q = (p >= d) ? p - d : p;
        if (p >= d) begin
          cnt[p] = count_t'(cnt_prev[p] + cnt_prev[q]);
        end
      end
    end
    sel_val = '0;
    for (int p = 0; p < N; p++) begin
      hit[p] = in_win[p] && (cnt[p] == kp1);
      if (hit[p]) begin
        sel_val = sel_val | val_r[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1_r) begin
      sel2_r  <= full1_r ? sel_val : '0;
      full2_r <= full1_r;
      last2_r <= last1_r;
    end
  end

  // Output stage: accumulate and present the result beat.
  logic signed [TOTAL_W-1:0] total_nxt;
  assign total_nxt = sum_r + TOTAL_W'(sel2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else if (adv) begin
      out_valid_r <= v2_r;
      if (v2_r) begin
        sum_r <= last2_r ? '0 : total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r) begin
      out_full_r  <= full2_r;
      out_sel_r   <= DATA_W'(sel2_r);
      out_total_r <= total_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_window_full    = out_full_r;
  assign out_selected_value = out_sel_r;
  assign out_running_total  = out_total_r;

  // Checks on the sorted window and the accumulator.
  logic [N-1:0] sorted_ok;
  always_comb begin
    sorted_ok[0] = 1'b1;
    for (int p = 1; p < N; p++) begin
      sorted_ok[p] = (val_r[p-1] <= val_r[p]);
    end
  end

  // Exactly one slot holds the oldest sample at all times.
  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(hot))
    else $error("sorted window does not hold exactly one oldest slot");

  // The value-sorted copy stays in ascending order.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    &sorted_ok)
    else $error("sorted window lost its order");

  // A full window selects exactly one slot.
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && full1_r) |-> $onehot(hit))
    else $error("rank select did not find exactly one slot");

  // The total restarts after the beat that closes a stream.
  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v2_r && last2_r) |=> (sum_r == '0))
    else $error("running total not cleared after last beat");

  // A result from a window that is not full carries a zero value.
  a_zero_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_full_r) |-> (out_sel_r == '0))
    else $error("selected value nonzero while window not full");

endmodule
